// ===== hw/rtl/arhm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arhm_pkg
// Shared widths, constants, types and helpers of the ring-and-hand mark shader.
// ----------------------------------------------------------------------------
package arhm_pkg;

    // Fixed-point format and image range
    localparam int FRAC_BITS = 8;
    localparam int ONE_FX    = 1 << FRAC_BITS;
    localparam int MAX_SIZE  = 1024;
    localparam int SIZE_W    = 11;
    localparam int PIX_W     = 10;

    // Datapath widths
    localparam int CW      = PIX_W + FRAC_BITS + 1;   // signed coordinate
    localparam int SQ_W    = 2 * CW;                  // sum of two squares
    localparam int ROOT_W  = SQ_W / 2;                // integer root
    localparam int REM_W   = ROOT_W + 2;              // root remainder
    localparam int LEN2_W  = 34;                      // hand length squared
    localparam int DOT_W   = 2 * CW;                  // projection numerator
    localparam int T_W     = FRAC_BITS + 1;           // t in 0..1
    localparam int COV_W   = FRAC_BITS + 1;           // coverage in 0..1
    localparam int DIST_W  = ROOT_W + 2;              // signed distance
    localparam int SUM_W   = 12;                      // sum of nine coverages
    localparam int ALPHA_W = 8;

    // Pipeline organization
    localparam int NSUB     = 3;                      // subsamples per axis
    localparam int NLANE    = NSUB * NSUB;
    localparam int DLY      = 9;                      // covers geometry settle time
    localparam int SMP_LAT  = 38;                     // sample lane latency
    localparam int PIPE_LEN = 1 + DLY + SMP_LAT + 4;

    // Design grid constants in hundredths of a grid unit
    localparam int G_N      = 7;
    localparam int G_CENTER = 0;
    localparam int G_RADIUS = 1;
    localparam int G_HALF   = 2;
    localparam int G_AX     = 3;
    localparam int G_AY     = 4;
    localparam int G_BX     = 5;
    localparam int G_BY     = 6;
    localparam logic [14:0] CH_TAB [G_N] = '{
        15'd17300, 15'd16050, 15'd1250, 15'd9449, 15'd11364, 15'd17183, 15'd18379
    };

    // Scaling: floor((Ch*s*2^F + 17300) / 34600) = floor((32*Ch*s + 2162) / 4325)
    localparam int N_W        = 25;
    localparam int M_W        = 30;
    localparam int P_W        = 50;
    localparam int Q_W        = 18;
    localparam int RECIP_SH   = 32;
    localparam logic [19:0] RECIP     = 20'd993056;  // floor(2^32 / 4325)
    localparam logic [12:0] SCALE_DIV = 13'd4325;
    localparam logic [11:0] ROUND_ADD = 12'd2162;

    // Stroke half-width floors
    localparam int RING_FLOOR = (4 * ONE_FX + 2) / 5;
    localparam int HAND_FLOOR = (3 * ONE_FX + 2) / 4;

    // Alpha: floor((510*sum + 9*2^F) / (18*2^F))
    localparam int ALPHA_MUL  = 2 * 255;
    localparam int ALPHA_ADD  = 9 * ONE_FX;
    localparam int ALPHA_SH   = FRAC_BITS + 1;
    localparam logic [12:0] NINTH_RECIP = 13'd7282;  // ceil(2^16 / 9)
    localparam int NINTH_SH   = 16;

    // Colors
    localparam logic [7:0] WHITE_LEVEL = 8'hFF;
    localparam logic [7:0] DARK_RG     = 8'h18;
    localparam logic [7:0] DARK_B      = 8'h1B;

    // Configuration map
    localparam int ADDR_W = 3;
    localparam logic REG_IMAGE_SIZE = 1'b0;
    localparam logic REG_WHITE_MODE = 1'b1;

    // Scaled geometry, stable between configuration writes
    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] radius;
        logic signed [CW-1:0] ring_hw;
        logic signed [CW-1:0] hand_hw;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] abx;
        logic signed [CW-1:0] aby;
        logic [LEN2_W-1:0]    len2;
    } geom_t;

    // Subsample offset (2s+1)/6 px, rounded
    function automatic logic [FRAC_BITS-1:0] sub_offset(input int s);
        int v;
        v = ((2 * s + 1) * ONE_FX + 3) / 6;
        return v[FRAC_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/arhm_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arhm_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module arhm_isqrt import arhm_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   radicand,
    output logic [ROOT_W-1:0] root
);

    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [SQ_W-1:0]   src_reg  [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   src_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign src_in  = radicand;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign src_in  = src_reg[k-1];
        end

        // bring down two bits and try the next root bit
        assign cur   = {rem_in, src_in[SQ_W-1 -: 2]};
        assign trial = (REM_W+2)'({root_in, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                src_reg[k]  <= src_in << 2;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ===== hw/rtl/arhm_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arhm_geom
// Scales the design-grid shapes to the image size; free-running, settles once a
// change of the size register has passed the clamp, scaling and derived registers.
// ----------------------------------------------------------------------------
module arhm_geom import arhm_pkg::*; (
    input  logic              aclk,
    input  logic [SIZE_W-1:0] image_size,
    output geom_t             geom
);

    logic [SIZE_W-1:0] s_reg;
    logic [N_W-1:0]    n_reg  [G_N];
    logic [M_W-1:0]    m_reg  [G_N];
    logic [P_W-1:0]    p_reg  [G_N];
    logic [M_W-1:0]    md_reg [G_N];
    logic [Q_W-1:0]    q0_reg [G_N];
    logic [M_W-1:0]    m2_reg [G_N];
    logic [Q_W-1:0]    q_reg  [G_N];

    logic signed [CW-1:0]   cx_reg, radius_reg, ring_hw_reg, hand_hw_reg;
    logic signed [CW-1:0]   ax_reg, ay_reg, abx_reg, aby_reg;
    logic [2*CW-1:0]        abx2_reg, aby2_reg;
    logic [LEN2_W-1:0]      len2_reg;
    logic signed [CW-1:0]   half_w;
    logic signed [2*CW-1:0] abx_sq, aby_sq;

    // clamp the size to 1..MAX_SIZE
    always_ff @(posedge aclk) begin
        if (image_size == '0) begin
            s_reg <= SIZE_W'(1);
        end else if (image_size > SIZE_W'(MAX_SIZE)) begin
            s_reg <= SIZE_W'(MAX_SIZE);
        end else begin
            s_reg <= image_size;
        end
    end

    // scale each constant: multiply, reciprocal divide, one correction
    always_ff @(posedge aclk) begin
        for (int i = 0; i < G_N; i++) begin
            n_reg[i]  <= CH_TAB[i] * s_reg;
            m_reg[i]  <= {n_reg[i], 5'b0} + M_W'(ROUND_ADD);
            p_reg[i]  <= P_W'(m_reg[i]) * P_W'(RECIP);
            md_reg[i] <= m_reg[i];
            q0_reg[i] <= p_reg[i][RECIP_SH +: Q_W];
            m2_reg[i] <= md_reg[i];
            q_reg[i]  <= q0_reg[i] + Q_W'(((M_W+1)'(m2_reg[i])
                          - (M_W+1)'(q0_reg[i]) * (M_W+1)'(SCALE_DIV))
                          >= (M_W+1)'(SCALE_DIV));
        end
    end

    assign half_w = $signed({1'b0, q_reg[G_HALF]});

    // full-width squares of the hand vector
    assign abx_sq = abx_reg * abx_reg;
    assign aby_sq = aby_reg * aby_reg;

    // derived shapes: floors and hand vector
    always_ff @(posedge aclk) begin
        cx_reg      <= $signed({1'b0, q_reg[G_CENTER]});
        radius_reg  <= $signed({1'b0, q_reg[G_RADIUS]});
        ring_hw_reg <= (half_w < CW'(RING_FLOOR)) ? CW'(RING_FLOOR) : half_w;
        hand_hw_reg <= (half_w < CW'(HAND_FLOOR)) ? CW'(HAND_FLOOR) : half_w;
        ax_reg      <= $signed({1'b0, q_reg[G_AX]});
        ay_reg      <= $signed({1'b0, q_reg[G_AY]});
        abx_reg     <= $signed({1'b0, q_reg[G_BX]}) - $signed({1'b0, q_reg[G_AX]});
        aby_reg     <= $signed({1'b0, q_reg[G_BY]}) - $signed({1'b0, q_reg[G_AY]});
        abx2_reg    <= $unsigned(abx_sq);
        aby2_reg    <= $unsigned(aby_sq);
        len2_reg    <= LEN2_W'(abx2_reg + aby2_reg);
    end

    assign geom.cx      = cx_reg;
    assign geom.cy      = cx_reg;
    assign geom.radius  = radius_reg;
    assign geom.ring_hw = ring_hw_reg;
    assign geom.hand_hw = hand_hw_reg;
    assign geom.ax      = ax_reg;
    assign geom.ay      = ay_reg;
    assign geom.abx     = abx_reg;
    assign geom.aby     = aby_reg;
    assign geom.len2    = len2_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/arhm_sample.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arhm_sample
// One subsample lane: ring and hand distances, coverage; 38-stage pipeline.
// ----------------------------------------------------------------------------
module arhm_sample import arhm_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  geom_t              geom,
    input  logic [CW-2:0]      px,
    input  logic [CW-2:0]      py,
    output logic [COV_W-1:0]   cov
);

    localparam logic [1:0] T_ZERO = 2'd0;
    localparam logic [1:0] T_ONE  = 2'd1;
    localparam logic [1:0] T_DIV  = 2'd2;
    localparam int MX_W = CW + T_W + 1;

    // stage 1..3: offsets, products, sums
    logic signed [CW-1:0]    dcx_reg, dcy_reg, apx1_reg, apy1_reg;
    logic [SQ_W-1:0]         dcx2_reg, dcy2_reg;
    logic signed [2*CW-1:0]  dpx_reg, dpy_reg;
    logic signed [CW-1:0]    apx2_reg, apy2_reg;
    logic [SQ_W-1:0]         rsum_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic signed [CW-1:0]    apx3_reg, apy3_reg;
    logic signed [SQ_W-1:0]  dcx_sq, dcy_sq;

    assign dcx_sq = dcx_reg * dcx_reg;
    assign dcy_sq = dcy_reg * dcy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dcx_reg  <= $signed({1'b0, px}) - geom.cx;
            dcy_reg  <= $signed({1'b0, py}) - geom.cy;
            apx1_reg <= $signed({1'b0, px}) - geom.ax;
            apy1_reg <= $signed({1'b0, py}) - geom.ay;
            dcx2_reg <= $unsigned(dcx_sq);
            dcy2_reg <= $unsigned(dcy_sq);
            dpx_reg  <= apx1_reg * geom.abx;
            dpy_reg  <= apy1_reg * geom.aby;
            apx2_reg <= apx1_reg;
            apy2_reg <= apy1_reg;
            rsum_reg <= dcx2_reg + dcy2_reg;
            dot_reg  <= dpx_reg + dpy_reg;
            apx3_reg <= apx2_reg;
            apy3_reg <= apy2_reg;
        end
    end

    // stage 4: classify the projection; stages 5..12: one quotient bit each
    logic [LEN2_W-1:0]    drem_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] dq_reg   [0:FRAC_BITS];
    logic [1:0]           dsel_reg [0:FRAC_BITS];
    logic signed [CW-1:0] dapx_reg [0:FRAC_BITS];
    logic signed [CW-1:0] dapy_reg [0:FRAC_BITS];
    logic signed [DOT_W-1:0] len2_s;

    assign len2_s = $signed(DOT_W'(geom.len2));

    always_ff @(posedge aclk) begin
        if (en) begin
            if (geom.len2 == '0 || dot_reg <= 0) begin
                dsel_reg[0] <= T_ZERO;
            end else if (dot_reg >= len2_s) begin
                dsel_reg[0] <= T_ONE;
            end else begin
                dsel_reg[0] <= T_DIV;
            end
            drem_reg[0] <= dot_reg[LEN2_W-1:0];
            dq_reg[0]   <= '0;
            dapx_reg[0] <= apx3_reg;
            dapy_reg[0] <= apy3_reg;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
        logic [LEN2_W:0] sh;
        logic            ge;
        assign sh = {drem_reg[k-1], 1'b0};
        assign ge = (sh >= {1'b0, geom.len2});
        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[k] <= ge ? LEN2_W'(sh - {1'b0, geom.len2}) : LEN2_W'(sh);
                dq_reg[k]   <= {dq_reg[k-1][FRAC_BITS-2:0], ge};
                dsel_reg[k] <= dsel_reg[k-1];
                dapx_reg[k] <= dapx_reg[k-1];
                dapy_reg[k] <= dapy_reg[k-1];
            end
        end
    end

    // stage 13..16: closest point on the hand and its squared distance
    logic [T_W-1:0]         t_w;
    logic signed [MX_W-1:0] mx_reg, my_reg;
    logic signed [CW-1:0]   apx13_reg, apy13_reg, qx_reg, qy_reg;
    logic [SQ_W-1:0]        qx2_reg, qy2_reg, hsum_reg;
    logic signed [MX_W-1:0] mx_sh, my_sh;
    logic signed [SQ_W-1:0] qx_sq, qy_sq;

    always_comb begin
        case (dsel_reg[FRAC_BITS])
            T_ONE:   t_w = T_W'(ONE_FX);
            T_DIV:   t_w = {1'b0, dq_reg[FRAC_BITS]};
            default: t_w = '0;
        endcase
    end

    assign mx_sh = mx_reg >>> FRAC_BITS;
    assign my_sh = my_reg >>> FRAC_BITS;
    assign qx_sq = qx_reg * qx_reg;
    assign qy_sq = qy_reg * qy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg    <= $signed({1'b0, t_w}) * geom.abx;
            my_reg    <= $signed({1'b0, t_w}) * geom.aby;
            apx13_reg <= dapx_reg[FRAC_BITS];
            apy13_reg <= dapy_reg[FRAC_BITS];
            qx_reg    <= apx13_reg - CW'(mx_sh);
            qy_reg    <= apy13_reg - CW'(my_sh);
            qx2_reg   <= $unsigned(qx_sq);
            qy2_reg   <= $unsigned(qy_sq);
            hsum_reg  <= qx2_reg + qy2_reg;
        end
    end

    // roots: ring ready at stage 22, hand at stage 35
    logic [ROOT_W-1:0] ring_root, hand_root;
    logic [ROOT_W-1:0] rdl_reg [0:12];

    arhm_isqrt u_ring_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (rsum_reg),
        .root     (ring_root)
    );

    arhm_isqrt u_hand_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (hsum_reg),
        .root     (hand_root)
    );

    // hold the ring root until the hand root catches up
    always_ff @(posedge aclk) begin
        if (en) begin
            rdl_reg[0] <= ring_root;
            for (int i = 1; i < 13; i++) begin
                rdl_reg[i] <= rdl_reg[i-1];
            end
        end
    end

    // stage 36..38: distances, minimum, clamped coverage
    logic signed [DIST_W-2:0] ra_reg, hd36_reg;
    logic signed [DIST_W-1:0] rd_reg, hd_reg;
    logic [COV_W-1:0]         cov_reg;
    logic signed [DIST_W-2:0] rabs_w;
    logic signed [DIST_W-1:0] dmin_w;
    logic signed [DIST_W:0]   c_w;

    assign rabs_w = (ra_reg < 0) ? -ra_reg : ra_reg;
    assign dmin_w = (rd_reg < hd_reg) ? rd_reg : hd_reg;
    assign c_w    = (DIST_W+1)'(ONE_FX / 2) - (DIST_W+1)'(dmin_w);

    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg   <= $signed({1'b0, rdl_reg[12]}) - (DIST_W-1)'(geom.radius);
            hd36_reg <= $signed({1'b0, hand_root}) - (DIST_W-1)'(geom.hand_hw);
            rd_reg   <= DIST_W'(rabs_w) - DIST_W'(geom.ring_hw);
            hd_reg   <= DIST_W'(hd36_reg);
            if (c_w < 0) begin
                cov_reg <= '0;
            end else if (c_w > (DIST_W+1)'(ONE_FX)) begin
                cov_reg <= COV_W'(ONE_FX);
            end else begin
                cov_reg <= c_w[COV_W-1:0];
            end
        end
    end

    assign cov = cov_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/antialiased_ring_hand_mark_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// antialiased_ring_hand_mark_pixel
// Shades one pixel of a ring-and-hand mark with 3x3 supersampled coverage.
// ----------------------------------------------------------------------------
// One pixel per clock while the output is not stalled: a new transaction can be
// taken in every cycle that s_tready is high. The pipeline is 52 stages deep;
// the depth is set by the two 19-stage square-root pipelines and the 8-stage
// projection divider in each of the nine subsample lanes, plus the pixel delay
// registers that cover the settling of the scaled geometry after image_size
// is written. A stall on the result side halts the whole pipeline; s_tready
// follows it.
// Registers: image_size at 0x0, white_mode at 0x4.
module antialiased_ring_hand_mark_pixel import arhm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // pixel input
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // pixel_x[9:0], pixel_y[19:10], zero
    // shaded output
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
);

    // configuration registers
    logic [SIZE_W-1:0] size_reg;
    logic              white_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= SIZE_W'(64);
            white_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[ADDR_W-1])
                REG_IMAGE_SIZE: size_reg  <= pwdata[SIZE_W-1:0];
                REG_WHITE_MODE: white_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1])
            REG_IMAGE_SIZE: prdata = 32'(size_reg);
            REG_WHITE_MODE: prdata = 32'(white_reg);
            default:        prdata = '0;
        endcase
    end

    // geometry
    geom_t geom;

    arhm_geom u_geom (
        .aclk       (aclk),
        .image_size (size_reg),
        .geom       (geom)
    );

    // advance the pipeline whenever the output register is free or taken
    logic                en;
    logic [PIPE_LEN-1:0] vld_reg;

    assign en       = m_tready | ~m_tvalid;
    assign s_tready = en;
    assign m_tvalid = vld_reg[PIPE_LEN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    // capture the pixel and delay it past the geometry settle time
    logic [PIX_W-1:0] x_reg [0:DLY];
    logic [PIX_W-1:0] y_reg [0:DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= s_tdata[PIX_W-1:0];
            y_reg[0] <= s_tdata[2*PIX_W-1:PIX_W];
            for (int i = 1; i <= DLY; i++) begin
                x_reg[i] <= x_reg[i-1];
                y_reg[i] <= y_reg[i-1];
            end
        end
    end

    // nine subsample lanes
    logic [COV_W-1:0] cov [NLANE];

    for (genvar sy = 0; sy < NSUB; sy++) begin : g_row
        for (genvar sx = 0; sx < NSUB; sx++) begin : g_col
            arhm_sample u_sample (
                .aclk (aclk),
                .en   (en),
                .geom (geom),
                .px   ({x_reg[DLY], sub_offset(sx)}),
                .py   ({y_reg[DLY], sub_offset(sy)}),
                .cov  (cov[sy*NSUB+sx])
            );
        end
    end

    // sum coverage and scale to alpha
    logic [SUM_W-1:0] sum_w, sum_reg;
    logic [20:0]      n_reg;
    logic [24:0]      prod_reg;
    logic [7:0]       red_reg, green_reg, blue_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    always_comb begin
        sum_w = '0;
        for (int i = 0; i < NLANE; i++) begin
            sum_w = sum_w + SUM_W'(cov[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= sum_w;
            n_reg     <= 21'(sum_reg * 21'(ALPHA_MUL)) + 21'(ALPHA_ADD);
            prod_reg  <= 25'(n_reg[20:ALPHA_SH]) * 25'(NINTH_RECIP);
            alpha_reg <= prod_reg[NINTH_SH +: ALPHA_W];
            red_reg   <= white_reg ? WHITE_LEVEL : DARK_RG;
            green_reg <= white_reg ? WHITE_LEVEL : DARK_RG;
            blue_reg  <= white_reg ? WHITE_LEVEL : DARK_B;
        end
    end

    assign m_tdata = {alpha_reg, blue_reg, green_reg, red_reg};

endmodule
`default_nettype wire
